// ----- rtl/core/psbm_pkg.sv -----
// psbm_pkg: shared types and constants for the pair selection bit matrix.
// Holds the item structs, op codes, microcode step names and control word.
// No dependencies.
`default_nettype none

package psbm_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_STATION_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE    = 2'd1;

	localparam logic [CFG_DATA_W-1:0] STATION_COUNT_RST = 7'd64;

	typedef enum logic [2:0] {
		OP_INIT       = 3'd0,
		OP_SEL_STN    = 3'd1,
		OP_SEL_PAIR   = 3'd2,
		OP_DESEL_STN  = 3'd3,
		OP_DESEL_PAIR = 3'd4,
		OP_QRY_PAIR   = 3'd5,
		OP_QRY_STN    = 3'd6,
		OP_NOP        = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0] op;
		logic [5:0] first_station;
		logic [5:0] second_station;
	} in_item_t;

	typedef struct packed {
		logic selected;
		logic index_error;
	} out_item_t;

	// microcode step addresses
	typedef enum logic [4:0] {
		S_IDLE,
		S_ERR,
		S_INIT,
		S_PSET_RD,
		S_PSET_WR,
		S_PCLR_RD,
		S_PCLR_WR,
		S_PQ_RD,
		S_PQ_OUT,
		S_SSET_RD,
		S_SSET_WR,
		S_SCLR_RD,
		S_SCLR_WR,
		S_STQ_CHK,
		S_REB_RD,
		S_REB_ACC,
		S_REB_FIN,
		S_STQ_OUT
	} step_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_ERR,
		EMIT_PAIR,
		EMIT_STN
	} emit_t;

	typedef enum logic [1:0] {
		COND_NEVER,
		COND_MORE,
		COND_FRESH
	} cond_t;

	// datapath control, one per microcode step
	typedef struct packed {
		logic  rd_en;
		logic  addr_cnt;
		logic  wr_en;
		logic  wr_sweep;
		logic  wr_val;
		logic  stn_pair;
		logic  stn_one;
		logic  do_init;
		logic  acc_clr;
		logic  reb_acc;
		logic  reb_fin;
		logic  set_stale;
		logic  cnt_inc;
		emit_t emit;
	} ctl_t;

	typedef struct packed {
		ctl_t  ctl;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} uword_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic bad;
		logic stale;
		logic more;
	} stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/psbm_ram.sv -----
// psbm_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`default_nettype none

module psbm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/psbm_seq.sv -----
// psbm_seq: microcode sequencer; step register, control ROM and op dispatch.
// Depends on psbm_pkg.
`default_nettype none

module psbm_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire psbm_pkg::op_t   op,
	input  wire psbm_pkg::stat_t stat,
	output psbm_pkg::ctl_t       ctl,
	output logic                 busy
);

	import psbm_pkg::*;

	step_t  upc_q;
	step_t  upc_d;
	uword_t w;
	logic   take;

	function automatic uword_t rom(input step_t s);
		uword_t u;
		u = '0;
		u.nxt = S_IDLE;
		u.jmp = S_IDLE;
		u.cond = COND_NEVER;
		unique case (s)
			S_IDLE: begin
			end
			S_ERR: begin
				u.ctl.emit = EMIT_ERR;
			end
			S_INIT: begin
				u.ctl.do_init = 1'b1;
			end
			S_PSET_RD: begin
				u.ctl.rd_en = 1'b1;
				u.nxt = S_PSET_WR;
			end
			S_PSET_WR: begin
				u.ctl.wr_en = 1'b1;
				u.ctl.wr_val = 1'b1;
				u.ctl.stn_pair = 1'b1;
			end
			S_PCLR_RD: begin
				u.ctl.rd_en = 1'b1;
				u.nxt = S_PCLR_WR;
			end
			S_PCLR_WR: begin
				u.ctl.wr_en = 1'b1;
				u.ctl.set_stale = 1'b1;
			end
			S_PQ_RD: begin
				u.ctl.rd_en = 1'b1;
				u.nxt = S_PQ_OUT;
			end
			S_PQ_OUT: begin
				u.ctl.emit = EMIT_PAIR;
			end
			S_SSET_RD: begin
				u.ctl.rd_en = 1'b1;
				u.ctl.addr_cnt = 1'b1;
				u.nxt = S_SSET_WR;
			end
			S_SSET_WR: begin
				u.ctl.wr_en = 1'b1;
				u.ctl.addr_cnt = 1'b1;
				u.ctl.wr_sweep = 1'b1;
				u.ctl.wr_val = 1'b1;
				u.ctl.stn_one = 1'b1;
				u.ctl.cnt_inc = 1'b1;
				u.cond = COND_MORE;
				u.jmp = S_SSET_RD;
			end
			S_SCLR_RD: begin
				u.ctl.rd_en = 1'b1;
				u.ctl.addr_cnt = 1'b1;
				u.nxt = S_SCLR_WR;
			end
			S_SCLR_WR: begin
				u.ctl.wr_en = 1'b1;
				u.ctl.addr_cnt = 1'b1;
				u.ctl.wr_sweep = 1'b1;
				u.ctl.stn_one = 1'b1;
				u.ctl.cnt_inc = 1'b1;
				u.cond = COND_MORE;
				u.jmp = S_SCLR_RD;
			end
			S_STQ_CHK: begin
				u.ctl.acc_clr = 1'b1;
				u.cond = COND_FRESH;
				u.jmp = S_STQ_OUT;
				u.nxt = S_REB_RD;
			end
			S_REB_RD: begin
				u.ctl.rd_en = 1'b1;
				u.ctl.addr_cnt = 1'b1;
				u.nxt = S_REB_ACC;
			end
			S_REB_ACC: begin
				u.ctl.reb_acc = 1'b1;
				u.ctl.cnt_inc = 1'b1;
				u.cond = COND_MORE;
				u.jmp = S_REB_RD;
				u.nxt = S_REB_FIN;
			end
			S_REB_FIN: begin
				u.ctl.reb_fin = 1'b1;
				u.nxt = S_STQ_OUT;
			end
			S_STQ_OUT: begin
				u.ctl.emit = EMIT_STN;
			end
			default: begin
			end
		endcase
		return u;
	endfunction

	function automatic step_t dispatch(input op_t o, input logic bad);
		step_t s;
		s = S_IDLE;
		if (o == OP_INIT) begin
			s = S_INIT;
		end else if (o != OP_NOP && bad) begin
			s = S_ERR;
		end else begin
			unique case (o)
				OP_SEL_STN:    s = S_SSET_RD;
				OP_SEL_PAIR:   s = S_PSET_RD;
				OP_DESEL_STN:  s = S_SCLR_RD;
				OP_DESEL_PAIR: s = S_PCLR_RD;
				OP_QRY_PAIR:   s = S_PQ_RD;
				OP_QRY_STN:    s = S_STQ_CHK;
				default:       s = S_IDLE;
			endcase
		end
		return s;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_comb begin
		w = rom(upc_q);
		ctl = w.ctl;
		busy = (upc_q != S_IDLE);
		unique case (w.cond)
			COND_MORE:  take = stat.more;
			COND_FRESH: take = !stat.stale;
			default:    take = 1'b0;
		endcase
		if (upc_q == S_IDLE) begin
			upc_d = accept ? dispatch(op, stat.bad) : S_IDLE;
		end else begin
			upc_d = take ? w.jmp : w.nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/psbm_datapath.sv -----
// psbm_datapath: row memory with row valid bits, station vector, stale flag,
// loop counter, rebuild accumulator and range check.
// Depends on psbm_pkg and psbm_ram.
`default_nettype none

module psbm_datapath #(
	parameter int MAX_STATIONS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire psbm_pkg::in_item_t  item,
	input  wire logic [6:0]          station_count,
	input  wire logic                fill_value,
	input  wire psbm_pkg::ctl_t      ctl,
	output psbm_pkg::stat_t          stat,
	output logic                     res_valid,
	output psbm_pkg::out_item_t      res
);

	import psbm_pkg::*;

	localparam int AW = $clog2(MAX_STATIONS);
	localparam int NW = $clog2(MAX_STATIONS + 1);
	localparam int CW = (NW > 7) ? NW : 7;

	logic [NW-1:0]           n;
	logic [MAX_STATIONS-1:0] nmask;
	logic                    pair_op;
	op_t                     in_op;

	logic [5:0]              a_q;
	logic [5:0]              b_q;
	logic [NW-1:0]           cnt_q;
	logic                    fill_q;
	logic                    stale_q;
	logic [MAX_STATIONS-1:0] vld_q;
	logic [MAX_STATIONS-1:0] stn_q;
	logic [MAX_STATIONS-1:0] acc_q;
	logic                    rvld_s1;

	logic [AW-1:0]           ra;
	logic [AW-1:0]           rb;
	logic [AW-1:0]           rc;
	logic [AW-1:0]           addr;
	logic [MAX_STATIONS-1:0] rdata;
	logic [MAX_STATIONS-1:0] row;
	logic [MAX_STATIONS-1:0] row_m;
	logic [MAX_STATIONS-1:0] wdata;

	// effective side length: min(station_count, MAX_STATIONS)
	always_comb begin
		if (CW'(station_count) < CW'(MAX_STATIONS)) begin
			n = NW'(station_count);
		end else begin
			n = NW'(MAX_STATIONS);
		end
		for (int i = 0; i < MAX_STATIONS; i++) begin
			nmask[i] = (CW'(i) < CW'(n));
		end
	end

	always_comb begin
		in_op = op_t'(item.op);
		pair_op = (in_op == OP_SEL_PAIR) || (in_op == OP_DESEL_PAIR) ||
			(in_op == OP_QRY_PAIR);
		stat.bad = (CW'(item.first_station) >= CW'(n)) ||
			(pair_op && (CW'(item.second_station) >= CW'(n)));
		stat.stale = stale_q;
		stat.more = ((cnt_q + NW'(1)) != n);
	end

	assign ra = AW'(a_q);
	assign rb = AW'(b_q);
	assign rc = AW'(cnt_q);
	assign addr = ctl.addr_cnt ? rc : ra;

	psbm_ram #(
		.WIDTH (MAX_STATIONS),
		.DEPTH (MAX_STATIONS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (addr),
		.wdata (wdata),
		.re    (ctl.rd_en),
		.raddr (addr),
		.rdata (rdata)
	);

	// rows never written since init read as the fill value
	assign row = rvld_s1 ? rdata : {MAX_STATIONS{fill_q}};
	assign row_m = row & nmask;

	always_comb begin
		wdata = row;
		if (ctl.wr_sweep) begin
			if (rc == ra) begin
				wdata = ctl.wr_val ? (wdata | nmask) : (wdata & ~nmask);
			end
			wdata[ra] = ctl.wr_val;
		end else begin
			wdata[rb] = ctl.wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= item.first_station;
			b_q <= item.second_station;
		end
		if (ctl.rd_en) begin
			rvld_s1 <= vld_q[addr];
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.reb_acc) begin
			acc_q <= acc_q | row_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fill_q <= 1'b0;
			stale_q <= 1'b0;
			vld_q <= '0;
			stn_q <= '0;
		end else begin
			if (accept) begin
				cnt_q <= '0;
			end else if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + NW'(1);
			end
			if (ctl.do_init) begin
				fill_q <= fill_value;
				stale_q <= 1'b0;
				vld_q <= '0;
				stn_q <= {MAX_STATIONS{fill_value}};
			end else begin
				if (ctl.wr_en) begin
					vld_q[addr] <= 1'b1;
				end
				if (ctl.set_stale) begin
					stale_q <= 1'b1;
				end else if (ctl.reb_fin) begin
					stale_q <= 1'b0;
				end
				if (ctl.stn_pair) begin
					stn_q <= stn_q | (MAX_STATIONS'(1) << ra) |
						(MAX_STATIONS'(1) << rb);
				end else if (ctl.stn_one) begin
					stn_q[ra] <= ctl.wr_val;
				end else if (ctl.reb_acc) begin
					stn_q[rc] <= |row_m;
				end else if (ctl.reb_fin) begin
					stn_q <= (stn_q | acc_q) & nmask;
				end
			end
		end
	end

	always_comb begin
		res_valid = (ctl.emit != EMIT_NONE);
		res.index_error = 1'b0;
		res.selected = 1'b0;
		case (ctl.emit)
			EMIT_ERR:  res.index_error = 1'b1;
			EMIT_PAIR: res.selected = row[rb];
			EMIT_STN:  res.selected = stn_q[ra];
			default:   res.selected = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/pair_selection_bit_matrix_top.sv -----
// Pair selection bit matrix: top level with configuration registers and
// result register. Depends on psbm_pkg, psbm_seq, psbm_datapath.
//
// Usage: an op is taken on a rising edge with start high and busy low. The
// matrix lives in a row-wide RAM (one row per station); each op runs as a
// short microcode program, busy stays high while it runs.
// Station select/deselect makes a pass over all n = min(station_count,
// MAX_STATIONS) rows; a station query is answered from the station vector
// when fresh and makes a rebuild pass over the rows when it is stale.
// Op code seven is taken and dropped without raising busy.
// Every row and column pass does a read then a write or accumulate per row,
// as each write or accumulate uses the row from the registered RAM read.
// A result appears on result for one cycle with result_valid, in the cycle
// after the last busy cycle; the receiver cannot stall it.
// Configuration beats on cfg_valid/cfg_ready are always taken; write them
// only while idle. Reset clears the matrix (row valid bits, no clearing
// pass), the station vector and stale flag, sets station_count to 64 and
// fill_value to 0.
`default_nettype none

module pair_selection_bit_matrix_top #(
	parameter int MAX_STATIONS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire psbm_pkg::in_item_t                  item,
	output logic                                     busy,
	output logic                                     result_valid,
	output psbm_pkg::out_item_t                      result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [psbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [psbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import psbm_pkg::*;

	logic                  accept;
	logic [CFG_DATA_W-1:0] station_count_q;
	logic                  fill_value_q;
	ctl_t                  ctl;
	stat_t                 stat;
	logic                  res_valid;
	out_item_t             res;

	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_count_q <= STATION_COUNT_RST;
			fill_value_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STATION_COUNT: station_count_q <= cfg_data;
				CFG_FILL_VALUE:    fill_value_q <= cfg_data[0];
				default:           fill_value_q <= fill_value_q;
			endcase
		end
	end

	psbm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (op_t'(item.op)),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	psbm_datapath #(
		.MAX_STATIONS (MAX_STATIONS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.item          (item),
		.station_count (station_count_q),
		.fill_value    (fill_value_q),
		.ctl           (ctl),
		.stat          (stat),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= res;
	end

endmodule

`default_nettype wire

// ----- rtl/core/psbm_checker.sv -----
// psbm_checker: port-level assertions for the pair selection bit matrix,
// bound to the top level. Depends on psbm_pkg.
`default_nettype none

module psbm_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire psbm_pkg::in_item_t  item,
	input wire logic                busy,
	input wire logic                result_valid,
	input wire psbm_pkg::out_item_t result
);

	import psbm_pkg::*;

	// a result beat is never followed directly by another
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result beat held for two cycles");

	// refused ops never report a selection
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.index_error |-> !result.selected)
		else $error("index error with selected set");

	// every result comes from an op that was running the cycle before
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a running op");

	// any real op that is taken raises busy in the next cycle
	a_op_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.op != OP_NOP) |=> busy)
		else $error("accepted op did not raise busy");

endmodule

bind pair_selection_bit_matrix_top psbm_checker u_psbm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.item         (item),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
